FILE: rtl/plwq_pkg.sv
`default_nettype none

package plwq_pkg;

	// field widths of a transaction
	localparam int unsigned PRIORITY_BITS = 8;
	localparam int unsigned ID_BITS       = 4;
	localparam int unsigned STATUS_BITS   = 3;

	// default number of waiter slots
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_GRANTED       = 3'd0,
		ST_QUEUED        = 3'd1,
		ST_FULL          = 3'd2,
		ST_RELEASED_NONE = 3'd3,
		ST_RELEASE_FREE  = 3'd4
	} status_t;

	typedef struct packed {
		logic                     opcode;
		logic [ID_BITS-1:0]       requester_id;
		logic [PRIORITY_BITS-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic                   grant_valid;
		logic [ID_BITS-1:0]     grant_id;
	} rsp_t;

	// one waiter slot
	typedef struct packed {
		logic [PRIORITY_BITS-1:0] prio;
		logic [ID_BITS-1:0]       id;
	} entry_t;

	// broadcast from the queue control to every cell
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t new_entry;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/priority_lock_waiter_queue_top.sv
`default_nettype none

// channel | signals                        | payload
// in      | in_valid, in_ready, in_data    | req_t: opcode, requester_id, priority_req
// out     | out_valid, out_ready, out_data | rsp_t: status, grant_valid, grant_id
//
// one transaction per cycle unless in_ready drops; each request is resolved
// in the cycle it is taken; the output register shows its response the next cycle
// the waiter queue is a row of QUEUE_DEPTH cells that insert or shift in step
// reset clears the lock flag, the waiter count and the output valid flag
// in_ready drops only while a held response is not taken by out_ready

module priority_lock_waiter_queue_top
	import plwq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  wire  out_ready,
	output rsp_t out_data
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	// lock and queue occupancy
	logic             lock_busy_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	rsp_t             out_q;

	logic             fire;
	logic             is_acq;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;
	rsp_t             rsp;
	logic             busy_nxt;

	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_ge    [QUEUE_DEPTH];

	// output register frees as soon as its response is taken
	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign is_acq    = (in_data.opcode == OP_ACQUIRE);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// queue control broadcast to the cells
	assign ctrl.insert              = fire && is_acq && lock_busy_q && !full;
	assign ctrl.pop                 = fire && !is_acq && lock_busy_q && !empty;
	assign ctrl.new_entry.prio      = in_data.priority_req;
	assign ctrl.new_entry.id        = in_data.requester_id;

	// response of this transaction and the next lock state
	always_comb begin
		rsp      = '0;
		busy_nxt = lock_busy_q;
		if (is_acq) begin
			if (!lock_busy_q) begin
				rsp.status      = ST_GRANTED;
				rsp.grant_valid = 1'b1;
				rsp.grant_id    = in_data.requester_id;
				busy_nxt        = 1'b1;
			end else if (full) begin
				rsp.status = ST_FULL;
			end else begin
				rsp.status = ST_QUEUED;
			end
		end else begin
			if (!lock_busy_q) begin
				rsp.status = ST_RELEASE_FREE;
			end else if (empty) begin
				// nobody waits, lock goes free
				rsp.status = ST_RELEASED_NONE;
				busy_nxt   = 1'b0;
			end else begin
				// straight handoff to the head waiter
				rsp.status      = ST_GRANTED;
				rsp.grant_valid = 1'b1;
				rsp.grant_id    = cell_entry[0].id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_busy_q <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				lock_busy_q <= busy_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// response payload needs no reset
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= rsp;
		end
	end

	// sorted waiter row, head at cell 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   left_ge;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_ge    = 1'b0;
			assign left_entry = ctrl.new_entry;
		end else begin : g_mid
			assign left_ge    = cell_ge[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_body
			assign right_entry = cell_entry[i+1];
		end

		plwq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (CNT_W'(i) < count_q),
			.left_ge     (left_ge),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.ge          (cell_ge[i])
		);
	end

	// waiters only exist while someone holds the lock
	a_wait_needs_holder: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> lock_busy_q)
		else $error("waiters present while lock is free");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("waiter count beyond queue depth");

	a_insert_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.insert && ctrl.pop))
		else $error("insert and pop in the same cycle");

	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.grant_valid |-> out_q.status == ST_GRANTED)
		else $error("grant without granted status");

	a_pop_grants: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> out_valid_q && out_q.grant_valid && lock_busy_q)
		else $error("handoff did not grant the head waiter");

endmodule

`default_nettype wire

FILE: rtl/plwq_cell.sv
`default_nettype none

module plwq_cell
	import plwq_pkg::*;
(
	input  wire        clk,
	input  cell_ctrl_t ctrl,
	input  wire        occupied,
	input  wire        left_ge,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	output entry_t     entry,
	output logic       ge
);

	entry_t entry_q;

	// this slot stays ahead of the new waiter (fifo among equal priorities)
	assign ge    = occupied && (entry_q.prio >= ctrl.new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			entry_q <= right_entry;
		end else if (ctrl.insert && !ge) begin
			if (left_ge) begin
				entry_q <= ctrl.new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;
	import plwq_pkg::*;

	localparam int unsigned DEPTH        = QUEUE_DEPTH_DEF;
	localparam int          RANDOM_ITEMS = 400;
	localparam int          CYCLE_LIMIT  = 200000;

	// tracks the lock and its waiter line, and holds the responses still owed
	class grant_scoreboard;
		bit     lock_held;
		entry_t waiter_line[$];
		rsp_t   pending_rsp[$];
		int     errors;

		function void take_request(req_t r);
			rsp_t   e;
			entry_t w;
			int     pos;
			e = '0;
			if (r.opcode == OP_ACQUIRE) begin
				if (!lock_held) begin
					lock_held     = 1'b1;
					e.status      = ST_GRANTED;
					e.grant_valid = 1'b1;
					e.grant_id    = r.requester_id;
				end else if (waiter_line.size() >= DEPTH) begin
					e.status = ST_FULL;
				end else begin
					// behind every waiter of equal or higher priority
					pos = 0;
					while (pos < waiter_line.size() && waiter_line[pos].prio >= r.priority_req)
						pos++;
					w.prio = r.priority_req;
					w.id   = r.requester_id;
					waiter_line.insert(pos, w);
					e.status = ST_QUEUED;
				end
			end else if (!lock_held) begin
				e.status = ST_RELEASE_FREE;
			end else if (waiter_line.size() == 0) begin
				lock_held = 1'b0;
				e.status  = ST_RELEASED_NONE;
			end else begin
				e.status      = ST_GRANTED;
				e.grant_valid = 1'b1;
				e.grant_id    = waiter_line[0].id;
				void'(waiter_line.pop_front());
			end
			pending_rsp.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding: status %0d id %0d",
					got.status, got.grant_id);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			if (got.status !== e.status) begin
				$error("status mismatch: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.grant_valid !== e.grant_valid) begin
				$error("grant_valid mismatch: expected %0d, actual %0d",
					e.grant_valid, got.grant_valid);
				errors++;
			end
			if (got.grant_id !== e.grant_id) begin
				$error("grant_id mismatch: expected %0d, actual %0d", e.grant_id, got.grant_id);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_rsp.size();
		endfunction
	endclass

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	req_t in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	grant_scoreboard board = new();
	int              cycle_count = 0;

	priority_lock_waiter_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hang ends the run as a failure
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// both channels are observed at the rising edge, before the block's
	// registers move, so request and response order never races
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.take_request(in_data);
			if (out_valid && out_ready)
				board.check_response(out_data);
		end
	end

	// receiver back-pressure: when the mode counter runs out, switch to a new stall mode
	int          ready_mode  = 0;
	int          mode_cycles = 0;
	logic [7:0]  ready_word  = 8'hff;
	always @(negedge clk) begin
		if (mode_cycles == 0) begin
			ready_mode  <= $urandom_range(0, 3);
			ready_word  <= 8'($urandom_range(0, 255)) | 8'h01;
			mode_cycles <= 63;
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;                          // never stalls
			1: out_ready <= 1'($urandom_range(0, 1));      // coin toss
			2: out_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
			default: out_ready <= ready_word[mode_cycles % 8];   // fixed pattern
		endcase
	end

	// present one transaction and hold it until taken; returns at a falling edge
	task automatic push_request(input req_t r);
		in_data  = r;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic idle_input(input int n);
		in_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// sender holds off until every owed response has come back
	task automatic wait_drained();
		in_valid = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
	endtask

	function automatic req_t make_req(input opcode_t op, input int id, input int prio);
		req_t r;
		r.opcode       = op;
		r.requester_id = ID_BITS'(id);
		r.priority_req = PRIORITY_BITS'(prio);
		return r;
	endfunction

	initial begin
		req_t directed[$];
		req_t r;
		int   fill_prio[16];
		int   sent;
		int   acq_pct;
		int   seg_left;
		int   burst;
		bit   paused;

		fill_prio = '{0, 255, 128, 128, 128, 7, 255, 1, 200, 200, 0, 64, 254, 3, 128, 99};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part, back to back
		// release while the lock is free, with junk in the ignored fields
		directed.push_back(make_req(OP_RELEASE, 5, 8'ha5));
		// grant on a free lock at the top id and priority
		directed.push_back(make_req(OP_ACQUIRE, 15, 255));
		// release with nobody waiting frees the lock
		directed.push_back(make_req(OP_RELEASE, 0, 0));
		directed.push_back(make_req(OP_ACQUIRE, 0, 0));
		// fill the waiter line: extremes and ties to exercise first-come order
		for (int k = 0; k < 16; k++)
			directed.push_back(make_req(OP_ACQUIRE, k, fill_prio[k]));
		// line full: rejected
		directed.push_back(make_req(OP_ACQUIRE, 9, 255));
		// two handoffs to the head waiter
		directed.push_back(make_req(OP_RELEASE, 15, 255));
		directed.push_back(make_req(OP_RELEASE, 10, 3));
		foreach (directed[i])
			push_request(directed[i]);
		wait_drained();

		// random part: segments with their own acquire/release mix so the line
		// swings between empty and full, sent in bursts with random gaps
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			acq_pct  = $urandom_range(15, 90);
			seg_left = $urandom_range(8, 40);
			while (seg_left > 0 && sent < RANDOM_ITEMS) begin
				burst = $urandom_range(1, 12);
				while (burst > 0 && seg_left > 0 && sent < RANDOM_ITEMS) begin
					r.opcode = ($urandom_range(0, 99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
					r.requester_id = ID_BITS'($urandom_range(0, 15));
					case ($urandom_range(0, 3))
						0: r.priority_req = $urandom_range(0, 1) ? 8'd255 : 8'd0;
						1: r.priority_req = PRIORITY_BITS'($urandom_range(1, 3) * 16);
						default: r.priority_req = PRIORITY_BITS'($urandom_range(0, 255));
					endcase
					push_request(r);
					sent++;
					burst--;
					seg_left--;
				end
				// some bursts run straight into the next
				if ($urandom_range(0, 2) != 0)
					idle_input($urandom_range(1, 6));
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		// let every owed response arrive, then let the clock run on before the verdict
		in_valid = 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (board.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
